@@ rtl/bcrm_pkg.sv @@
// Shared types and constants for the byte counter rate meter.
`default_nettype none
package bcrm_pkg;

   localparam int SLOT_COUNT_DEFAULT = 16;

   // Field widths of the beats
   localparam int SLOT_W    = 4;
   localparam int COUNT_W   = 32;
   localparam int ELAPSED_W = 24;
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 72;

   // 100 * delta needs 39 bits, so does the quotient before saturation
   localparam int NUM_W     = COUNT_W + 7;
   localparam int DIV_STEPS = NUM_W;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   localparam logic [COUNT_W-1:0] RATE_MAX = '1;

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_ROUND  = 1'b1;
   localparam logic KIND_RATES    = 1'b0;
   localparam logic KIND_TOTALS   = 1'b1;

   typedef struct packed {
      logic capture;    // latch the request beat, start baseline read
      logic end_round;  // unprime unseen slots, clear seen flags
      logic wr_base;    // store new readings as baseline
      logic load_div;   // load deltas * 100 into the dividers
      logic div_step;   // one quotient bit per divider
      logic emit;       // load the response register
   } cmd_type;

   typedef struct packed {
      logic action;
      logic slot_ok;
      logic primed;
      logic out_free;
   } status_type;

endpackage : bcrm_pkg
`default_nettype wire

@@ rtl/bcrm_ctrl.sv @@
// Sequencer for the byte counter rate meter.
`default_nettype none
module bcrm_ctrl
   import bcrm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type st,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {S_IDLE, S_DECODE, S_DIV, S_EMIT} state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (st.action == ACTION_ROUND) begin
               cmd.end_round = 1'b1;
               state_in      = S_EMIT;
            end else if (!st.slot_ok) begin
               state_in = S_IDLE;
            end else if (!st.primed) begin
               cmd.wr_base = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.wr_base  = 1'b1;
               cmd.load_div = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold until the response register is free
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule : bcrm_ctrl
`default_nettype wire

@@ rtl/bcrm_dp.sv @@
// Datapath: baseline store, slot flags, two bit-serial dividers, totals, response register.
`default_nettype none
module bcrm_dp
   import bcrm_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  st,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tuser
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Captured request beat
   logic                 action_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [COUNT_W-1:0]   in_ff, out_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;

   // Baseline memory: {out reading, in reading}
   logic [2*COUNT_W-1:0] base_mem [SLOT_COUNT];
   logic [2*COUNT_W-1:0] base_rd_ff;

   logic [SLOT_COUNT-1:0] valid_ff, seen_ff;

   logic [NUM_W-1:0]     qa_ff, qb_ff;
   logic [ELAPSED_W:0]   ra_ff, rb_ff;
   logic [COUNT_W-1:0]   tot_in_ff, tot_out_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_kind_ff;
   logic [SLOT_W-1:0]      rsp_slot_ff;
   logic [COUNT_W-1:0]     rsp_rin_ff, rsp_rout_ff;

   logic [IDX_W-1:0]   req_idx, idx;
   logic [COUNT_W-1:0] d_in, d_out;
   logic [NUM_W-1:0]   num_in, num_out;
   logic [ELAPSED_W:0] sa, sb;
   logic               ga, gb;
   logic [COUNT_W-1:0] rate_in, rate_out;
   logic [COUNT_W:0]   sum_in, sum_out;

   assign req_idx = IDX_W'(req_tdata[SLOT_W-1:0]);
   assign idx     = IDX_W'(slot_ff);

   function automatic logic [NUM_W-1:0] times100(input logic [COUNT_W-1:0] d);
      logic [NUM_W-1:0] e;
      e = NUM_W'(d);
      return (e << 6) + (e << 5) + (e << 2);
   endfunction

   // Quotient above 32 bits saturates; zero elapsed time gives zero
   function automatic logic [COUNT_W-1:0] sat_rate(input logic [NUM_W-1:0] q,
                                                   input logic zero_div);
      logic [COUNT_W-1:0] r;
      if (zero_div) begin
         r = '0;
      end else if (q[NUM_W-1:COUNT_W] != '0) begin
         r = RATE_MAX;
      end else begin
         r = q[COUNT_W-1:0];
      end
      return r;
   endfunction

   assign d_in    = in_ff  - base_rd_ff[COUNT_W-1:0];
   assign d_out   = out_ff - base_rd_ff[2*COUNT_W-1:COUNT_W];
   assign num_in  = times100(d_in);
   assign num_out = times100(d_out);

   // Restoring division step: shift in next dividend bit, subtract if it fits
   assign sa = {ra_ff[ELAPSED_W-1:0], qa_ff[NUM_W-1]};
   assign sb = {rb_ff[ELAPSED_W-1:0], qb_ff[NUM_W-1]};
   assign ga = (sa >= {1'b0, elapsed_ff});
   assign gb = (sb >= {1'b0, elapsed_ff});

   assign rate_in  = sat_rate(qa_ff, elapsed_ff == '0);
   assign rate_out = sat_rate(qb_ff, elapsed_ff == '0);
   assign sum_in   = {1'b0, tot_in_ff}  + {1'b0, rate_in};
   assign sum_out  = {1'b0, tot_out_ff} + {1'b0, rate_out};

   assign st.action   = action_ff;
   assign st.slot_ok  = (32'(slot_ff) < SLOT_COUNT);
   assign st.primed   = valid_ff[idx];
   assign st.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= req_tuser;
         slot_ff    <= req_tdata[SLOT_W-1:0];
         in_ff      <= req_tdata[SLOT_W +: COUNT_W];
         out_ff     <= req_tdata[SLOT_W+COUNT_W +: COUNT_W];
         elapsed_ff <= req_tdata[SLOT_W+2*COUNT_W +: ELAPSED_W];
         base_rd_ff <= base_mem[req_idx];
      end
      if (cmd.wr_base) begin
         base_mem[idx] <= {out_ff, in_ff};
      end
      if (cmd.load_div) begin
         qa_ff <= num_in;
         qb_ff <= num_out;
         ra_ff <= '0;
         rb_ff <= '0;
      end else if (cmd.div_step) begin
         qa_ff <= {qa_ff[NUM_W-2:0], ga};
         qb_ff <= {qb_ff[NUM_W-2:0], gb};
         ra_ff <= ga ? (sa - {1'b0, elapsed_ff}) : sa;
         rb_ff <= gb ? (sb - {1'b0, elapsed_ff}) : sb;
      end
      if (cmd.emit) begin
         rsp_kind_ff <= action_ff;
         if (action_ff == ACTION_ROUND) begin
            rsp_slot_ff <= '0;
            rsp_rin_ff  <= tot_in_ff;
            rsp_rout_ff <= tot_out_ff;
         end else begin
            rsp_slot_ff <= slot_ff;
            rsp_rin_ff  <= rate_in;
            rsp_rout_ff <= rate_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         seen_ff      <= '0;
         tot_in_ff    <= '0;
         tot_out_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.end_round) begin
            valid_ff <= valid_ff & seen_ff;
            seen_ff  <= '0;
         end else if (cmd.wr_base) begin
            valid_ff[idx] <= 1'b1;
            seen_ff[idx]  <= 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            if (action_ff == ACTION_ROUND) begin
               tot_in_ff  <= '0;
               tot_out_ff <= '0;
            end else begin
               tot_in_ff  <= sum_in[COUNT_W]  ? RATE_MAX : sum_in[COUNT_W-1:0];
               tot_out_ff <= sum_out[COUNT_W] ? RATE_MAX : sum_out[COUNT_W-1:0];
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - SLOT_W - 2*COUNT_W)'(0),
                        rsp_rout_ff, rsp_rin_ff, rsp_slot_ff};

endmodule : bcrm_dp
`default_nettype wire

@@ rtl/byte_counter_rate_meter_unit.sv @@
// Top level of the byte counter rate meter.
//
// Meters byte throughput for up to SLOT_COUNT interfaces from raw 32-bit counter
// samples. A sample beat (tuser 0) for an unprimed slot only stores the readings;
// on a primed slot it emits floor(100 * delta / elapsed) bytes per second for each
// direction, saturated to 32 bits, and zero when elapsed is zero. An end-of-round
// beat (tuser 1) unprimes slots not sampled during the round and emits the round's
// saturating totals with slot 0. One item is worked at a time: a metered sample
// passes through accept, decode, 39 steps of the two bit-serial dividers and emit,
// an end-of-round beat through accept, decode and emit, a priming or out-of-range
// sample through accept and decode; emit waits while a previous response is still held on rsp_tvalid.
`default_nettype none
module byte_counter_rate_meter_unit
   import bcrm_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // slot[3:0], bytes_in_count[35:4], bytes_out_count[67:36],
   // elapsed_hundredths[91:68], zero[95:92]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // action[0]
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // result_slot[3:0], rate_in[35:4], rate_out[67:36], zero[71:68]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // result_kind[0]
   output logic                        rsp_tuser
);

   cmd_type    cmd;
   status_type st;

   bcrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bcrm_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Totals always carry slot zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_TOTALS) |-> (rsp_tdata[SLOT_W-1:0] == '0))
      else $error("round totals with nonzero slot");

   // Rates only for slots in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_RATES) |-> (32'(rsp_tdata[SLOT_W-1:0]) < SLOT_COUNT))
      else $error("rates for out-of-range slot");

   // One item at a time: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("back-to-back accept");

   // A new response is only loaded into a free register
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> st.out_free)
      else $error("response overwritten");

endmodule : byte_counter_rate_meter_unit
`default_nettype wire
